/* src/slottab_pkg.sv */
package slottab_pkg;

    // Default table geometry.
    localparam int SLOTS_DEFAULT   = 128;
    localparam int ID_BITS_DEFAULT = 16;

    // Fixed field widths of the request and response.
    localparam int KIND_W   = 2;
    localparam int SID_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 7;
    localparam int AID_W    = 16;
    localparam int CFG_W    = 8;

    // Reset value of the slots-in-use register.
    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 8'd128;

    // Operation codes.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    // Response status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SID_W-1:0]  search_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [AID_W-1:0]    assigned_id;
    } rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_FIND,
        ST_RESP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic ins_step;
        logic find_step;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ins_done;
        logic find_done;
        logic out_free;
    } sts_t;

endpackage

/* src/slottab_ram.sv */
module slottab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/slottab_ctrl.sv */
module slottab_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [slottab_pkg::KIND_W-1:0] req_kind,
    input  slottab_pkg::sts_t         sts,
    output slottab_pkg::cmd_t         cmd
);
    import slottab_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (req_kind == KIND_INSERT) begin
                        state_next = ST_INSERT;
                    end else if (req_kind == KIND_REMOVE || req_kind == KIND_LOOKUP) begin
                        state_next = ST_FIND;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_INSERT: begin
                if (sts.ins_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_FIND: begin
                if (sts.find_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready       = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            ST_INSERT: cmd.ins_step  = 1'b1;
            ST_FIND:   cmd.find_step = 1'b1;
            ST_RESP:   cmd.load_out  = sts.out_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* src/slottab_dp.sv */
module slottab_dp #(
    parameter int SLOTS   = slottab_pkg::SLOTS_DEFAULT,
    parameter int ID_BITS = slottab_pkg::ID_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [slottab_pkg::CFG_W-1:0] cfg_wdata,
    input  slottab_pkg::req_t             s_data,
    input  slottab_pkg::cmd_t             cmd,
    output slottab_pkg::sts_t             sts,
    output logic                          m_valid,
    input  logic                          m_ready,
    output slottab_pkg::rsp_t             m_data
);
    import slottab_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [CFG_W-1:0]   slots_in_use_reg;
    logic [SLOTS-1:0]   used_reg;
    logic [ID_BITS-1:0] id_counter_reg;
    req_t               req_reg;
    logic [ID_BITS-1:0] sid_reg;
    logic [CNT_W-1:0]   issue_reg;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    rsp_t               res_reg;
    logic               m_valid_reg;
    rsp_t               m_data_reg;

    logic [CNT_W+CFG_W-1:0]  sui_ext;
    logic [CNT_W-1:0]        active_n;
    logic [SID_W+ID_BITS-1:0] sid_ext;
    logic [IDX_W-1:0]        issue_idx;
    logic                    issue_ok;
    logic [ID_BITS-1:0]      ram_rdata;
    logic                    ram_we;
    logic [ID_BITS-1:0]      id_next;
    logic                    ins_free;
    logic                    find_hit;
    logic [IDX_W+SLOT_W-1:0] issue_slot_ext;
    logic [IDX_W+SLOT_W-1:0] cmp_slot_ext;
    logic [ID_BITS+AID_W-1:0] new_id_ext;
    logic [ID_BITS+AID_W-1:0] sid_id_ext;

    // Number of slots searched, saturated at the table size.
    assign sui_ext  = {{CNT_W{1'b0}}, slots_in_use_reg};
    assign active_n = (sui_ext > (CNT_W + CFG_W)'(SLOTS)) ? CNT_W'(SLOTS)
                                                          : sui_ext[CNT_W-1:0];

    // Search id masked to the id width.
    assign sid_ext = {{ID_BITS{1'b0}}, s_data.search_id};

    assign issue_idx = issue_reg[IDX_W-1:0];
    assign issue_ok  = issue_reg < active_n;

    // Next id from the running counter; zero is skipped on wrap.
    assign id_next = (id_counter_reg == {ID_BITS{1'b1}}) ? ID_BITS'(1)
                                                         : id_counter_reg + ID_BITS'(1);

    // Insert finds a free slot at the current scan index.
    assign ins_free = issue_ok && !used_reg[issue_idx];
    assign ram_we   = cmd.ins_step && ins_free;

    // Lookup compares the id read in the previous cycle.
    assign find_hit = cmp_valid_reg && used_reg[cmp_idx_reg] && (ram_rdata == sid_reg);

    assign sts.ins_done  = !issue_ok || !used_reg[issue_idx];
    assign sts.find_done = find_hit || (!cmp_valid_reg && !issue_ok);
    assign sts.out_free  = !m_valid_reg || m_ready;

    // Response fields narrowed to their fixed widths.
    assign issue_slot_ext = {{SLOT_W{1'b0}}, issue_idx};
    assign cmp_slot_ext   = {{SLOT_W{1'b0}}, cmp_idx_reg};
    assign new_id_ext     = {{AID_W{1'b0}}, id_next};
    assign sid_id_ext     = {{AID_W{1'b0}}, sid_reg};

    slottab_ram #(
        .WIDTH(ID_BITS),
        .DEPTH(SLOTS)
    ) u_ids (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(issue_idx),
        .wdata(id_next),
        .raddr(issue_idx),
        .rdata(ram_rdata)
    );

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg <= SLOTS_IN_USE_RESET;
        end else if (cfg_wen) begin
            slots_in_use_reg <= cfg_wdata;
        end
    end

    // Used marks and the id counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            id_counter_reg <= '0;
        end else begin
            if (ram_we) begin
                used_reg[issue_idx] <= 1'b1;
                id_counter_reg      <= id_next;
            end
            if (cmd.find_step && find_hit && req_reg.kind == KIND_REMOVE) begin
                used_reg[cmp_idx_reg] <= 1'b0;
            end
        end
    end

    // Scan counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end else if (cmd.start) begin
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end else if (cmd.ins_step) begin
            if (issue_ok) begin
                issue_reg <= issue_reg + CNT_W'(1);
            end
        end else if (cmd.find_step) begin
            cmp_valid_reg <= issue_ok;
            if (issue_ok) begin
                issue_reg <= issue_reg + CNT_W'(1);
            end
        end
    end

    // Request latch, compare index and result.
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= issue_idx;
        if (cmd.start) begin
            req_reg     <= s_data;
            sid_reg     <= sid_ext[ID_BITS-1:0];
            res_reg     <= '{status: STATUS_NOT_FOUND, slot: '0, assigned_id: '0};
        end else if (cmd.ins_step) begin
            if (ins_free) begin
                res_reg <= '{status: STATUS_DONE,
                             slot: issue_slot_ext[SLOT_W-1:0],
                             assigned_id: new_id_ext[AID_W-1:0]};
            end else if (!issue_ok) begin
                res_reg <= '{status: STATUS_FULL, slot: '0, assigned_id: '0};
            end
        end else if (cmd.find_step && find_hit) begin
            res_reg <= '{status: STATUS_DONE,
                         slot: cmp_slot_ext[SLOT_W-1:0],
                         assigned_id: sid_id_ext[AID_W-1:0]};
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* src/slot_table_with_id_allocation_unit.sv */
// Slot table with id allocation.
// Requests arrive on the s_ channel (valid/ready, payload s_data: kind and
// search_id) and each gives exactly one response on the m_ channel (payload
// m_data: status, slot, assigned_id). An insert takes the lowest free slot and
// gives it the next id; a remove or lookup finds the lowest used slot whose id
// matches. cfg_wen/cfg_wdata set the number of slots searched.
// One request is worked at a time. An insert scans upward from slot 0 to
// the first free slot; a remove or lookup scans up to N slots, N being the
// slots searched, reading one stored id per cycle from the id RAM, whose
// read is registered.
// The response sits in an output register; the next request is accepted while
// it waits, but that request's response waits until the receiver takes the
// previous one, and no further request is accepted meanwhile.
// Reset (aresetn low, synchronous) frees every slot, clears the id counter so
// the first id is 1, and sets the slots-in-use register to 128.
module slot_table_with_id_allocation_unit #(
    parameter int SLOTS   = slottab_pkg::SLOTS_DEFAULT,
    parameter int ID_BITS = slottab_pkg::ID_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wen,
    input  logic [slottab_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  slottab_pkg::req_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output slottab_pkg::rsp_t             m_data
);
    import slottab_pkg::*;

    cmd_t cmd;
    sts_t sts;

    slottab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .req_kind(s_data.kind),
        .sts     (sts),
        .cmd     (cmd)
    );

    slottab_dp #(
        .SLOTS  (SLOTS),
        .ID_BITS(ID_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_data   (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* tb/testbench.sv */
module testbench;
    import slottab_pkg::*;

    localparam int TABLE_SLOTS    = SLOTS_DEFAULT;
    localparam int IDLE_PCT       = 23;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 130;
    localparam int B2B_ROUNDS     = 50;
    localparam int MAX_REPORTS    = 10;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [AID_W-1:0]  ID_MAX      = '1;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wen   = 1'b0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    req_t              s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    rsp_t              m_data;

    // Shadow copy of the table, the id counter and the slot count.
    logic              mdl_used [TABLE_SLOTS];
    logic [AID_W-1:0]  mdl_ids  [TABLE_SLOTS];
    logic [AID_W-1:0]  last_id;
    logic [CFG_W-1:0]  slot_limit;

    rsp_t pending_answers[$];
    int   error_count = 0;
    int   stall_cycles = 0;
    bit   no_idle = 1'b0;
    bit   hold_req = 1'b0;
    int   hold_left = 0;

    slot_table_with_id_allocation_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Free-running clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Works out the answer to one request and updates the shadow table.
    function automatic rsp_t apply_table_op(input req_t r);
        rsp_t o;
        int   n;
        int   hit;
        o = '0;
        o.status = STATUS_NOT_FOUND;
        n = (slot_limit > TABLE_SLOTS) ? TABLE_SLOTS : int'(slot_limit);
        hit = -1;
        if (r.kind == KIND_INSERT) begin
            for (int i = 0; i < n; i++) begin
                if (hit < 0 && !mdl_used[i]) hit = i;
            end
            if (hit < 0) begin
                o.status = STATUS_FULL;
            end else begin
                // The counter skips zero when it wraps.
                last_id = (last_id == ID_MAX) ? AID_W'(1) : last_id + AID_W'(1);
                mdl_used[hit] = 1'b1;
                mdl_ids[hit] = last_id;
                o.status = STATUS_DONE;
                o.slot = hit[SLOT_W-1:0];
                o.assigned_id = last_id;
            end
        end else if (r.kind == KIND_REMOVE || r.kind == KIND_LOOKUP) begin
            for (int i = 0; i < n; i++) begin
                if (hit < 0 && mdl_used[i] && mdl_ids[i] == r.search_id) hit = i;
            end
            if (hit >= 0) begin
                if (r.kind == KIND_REMOVE) mdl_used[hit] = 1'b0;
                o.status = STATUS_DONE;
                o.slot = hit[SLOT_W-1:0];
                o.assigned_id = r.search_id;
            end
        end
        return o;
    endfunction

    // Offers one request, waits for it to be taken and records its answer.
    task automatic send_req(input logic [KIND_W-1:0] kind, input logic [SID_W-1:0] sid);
        req_t r;
        r.kind = kind;
        r.search_id = sid;
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_answers.push_back(apply_table_op(r));
    endtask

    // Stops offering and waits until every answer has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes the slot count while the block is idle.
    task automatic write_slots(input logic [CFG_W-1:0] v);
        wait_idle();
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        slot_limit = v;
        cfg_wen <= 1'b0;
        cfg_wdata <= CFG_W'($urandom_range(255));
        @(posedge aclk);
    endtask

    // Frees every used slot, lowest first, by removing its id.
    task automatic clear_table();
        write_slots(CFG_W'(TABLE_SLOTS));
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (mdl_used[i]) send_req(KIND_REMOVE, mdl_ids[i]);
        end
    endtask

    // Each operation on a nearly empty table, with the odd search ids.
    task automatic test_basic_ops();
        send_req(KIND_LOOKUP, 16'd1);
        send_req(KIND_INSERT, 16'h0000);
        send_req(KIND_INSERT, 16'hFFFF);
        send_req(KIND_INSERT, 16'h5A5A);
        send_req(KIND_LOOKUP, 16'd2);
        send_req(KIND_REMOVE, 16'd2);
        send_req(KIND_LOOKUP, 16'd2);
        send_req(KIND_INSERT, 16'hA5A5);
        send_req(KIND_LOOKUP, 16'd0);
        send_req(KIND_LOOKUP, 16'hFFFF);
        send_req(KIND_REMOVE, 16'hFFFF);
        send_req(KIND_UNUSED, 16'd1);
        send_req(KIND_UNUSED, 16'hFFFF);
        send_req(KIND_REMOVE, 16'd1);
        send_req(KIND_REMOVE, 16'd3);
        send_req(KIND_REMOVE, 16'd4);
    endtask

    // No slots searched, a count above the table size, and a single slot.
    task automatic test_slot_count_extremes();
        write_slots(8'd0);
        send_req(KIND_INSERT, 16'd0);
        send_req(KIND_LOOKUP, 16'd1);
        send_req(KIND_REMOVE, 16'd1);
        write_slots(8'd255);
        send_req(KIND_INSERT, 16'd0);
        send_req(KIND_LOOKUP, last_id);
        write_slots(8'd1);
        send_req(KIND_INSERT, 16'd0);
        send_req(KIND_LOOKUP, last_id);
        send_req(KIND_REMOVE, last_id);
    endtask

    // Fills all slots, then hides the upper ones by lowering the count.
    task automatic test_full_table();
        logic [AID_W-1:0] hidden_id;
        write_slots(CFG_W'(TABLE_SLOTS));
        for (int i = 0; i <= TABLE_SLOTS; i++) send_req(KIND_INSERT, SID_W'($urandom));
        send_req(KIND_LOOKUP, mdl_ids[TABLE_SLOTS-1]);
        hidden_id = mdl_ids[100];
        write_slots(8'd4);
        send_req(KIND_LOOKUP, hidden_id);
        send_req(KIND_REMOVE, hidden_id);
        send_req(KIND_INSERT, 16'd0);
        send_req(KIND_LOOKUP, mdl_ids[3]);
        clear_table();
        send_req(KIND_LOOKUP, hidden_id);
    endtask

    // Inserts, lookups and removes back to back with no idle cycle on either side.
    task automatic test_back_to_back();
        write_slots(8'd4);
        no_idle = 1'b1;
        for (int i = 0; i < B2B_ROUNDS; i++) begin
            send_req(KIND_INSERT, SID_W'($urandom));
            send_req(KIND_LOOKUP, last_id);
            send_req(KIND_REMOVE, last_id);
        end
        no_idle = 1'b0;
    endtask

    // The receiver holds off for a long time while requests keep coming.
    task automatic test_backpressure();
        write_slots(8'd8);
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_req((i % 3 == 2) ? KIND_LOOKUP : KIND_INSERT, last_id);
        end
    endtask

    // The sender stops until every answer is back, then resumes.
    task automatic test_sender_pause();
        for (int i = 0; i < 4; i++) send_req(KIND_REMOVE, last_id - AID_W'(i));
        wait_idle();
        for (int i = 0; i < 4; i++) send_req(KIND_INSERT, SID_W'($urandom));
        clear_table();
    endtask

    // Random requests, mostly on live ids, over several slot counts.
    task automatic test_random();
        logic [CFG_W-1:0] phase_cfg[8];
        int live[$];
        int p;
        logic [KIND_W-1:0] k;
        logic [SID_W-1:0] sid;
        phase_cfg = '{8'd1, 8'd3, 8'd8, 8'd128, 8'd0, 8'd255, 8'd2, 8'd16};
        phase_cfg[7] = CFG_W'($urandom_range(1, TABLE_SLOTS - 1));
        foreach (phase_cfg[ph]) begin
            write_slots(phase_cfg[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                live = {};
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (mdl_used[i]) live.push_back(i);
                end
                p = $urandom_range(99);
                sid = SID_W'($urandom);
                if (p < 40) begin
                    k = KIND_INSERT;
                end else if (p < 85) begin
                    k = ($urandom_range(1) != 0) ? KIND_REMOVE : KIND_LOOKUP;
                    if (live.size() != 0 && p < 80)
                        sid = mdl_ids[live[$urandom_range(live.size() - 1)]];
                end else if (p < 95) begin
                    k = KIND_W'($urandom_range(3));
                end else begin
                    k = KIND_UNUSED;
                end
                send_req(k, sid);
            end
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Each answer taken is compared with the oldest one still owed.
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("unexpected answer: status=%0d slot=%0d id=%0d",
                             m_data.status, m_data.slot, m_data.assigned_id);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (m_data.status !== want.status || m_data.slot !== want.slot ||
                    m_data.assigned_id !== want.assigned_id) begin
                    if (error_count < MAX_REPORTS) begin
                        $display("answer mismatch: expected status=%0d slot=%0d id=%0d",
                                 want.status, want.slot, want.assigned_id);
                        $display("                 got      status=%0d slot=%0d id=%0d",
                                 m_data.status, m_data.slot, m_data.assigned_id);
                    end
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel has moved for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) stall_cycles = 0;
        else stall_cycles = stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("slot_table_with_id_allocation_unit verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            mdl_used[i] = 1'b0;
            mdl_ids[i] = '0;
        end
        last_id = '0;
        slot_limit = SLOTS_IN_USE_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_ops();
        test_slot_count_extremes();
        test_full_table();
        test_back_to_back();
        test_backpressure();
        test_sender_pause();
        test_random();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && pending_answers.size() == 0) begin
            $display("slot_table_with_id_allocation_unit verification clean");
        end else begin
            $display("slot_table_with_id_allocation_unit verification failed");
        end
        $finish;
    end
endmodule
